/* design/bdll_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bdll_pkg: shared types for the bounded doubly linked list
// request and status codes, beat structs, sequencer states
// ----------------------------------------------------------------------------
package bdll_pkg;

  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_INSERT     = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_POP_BACK   = 3'd4,
    REQ_REMOVE     = 3'd5,
    REQ_FIND       = 3'd6,
    REQ_CLEAR      = 3'd7
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_ALLOC_W = 8'b0000_0010,
    S_LINK1   = 8'b0000_0100,
    S_LINK2   = 8'b0000_1000,
    S_SRCH    = 8'b0001_0000,
    S_UNLINK  = 8'b0010_0000,
    S_FIXV    = 8'b0100_0000,
    S_RESP    = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] new_value;
    logic signed [31:0] match_key;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [8:0]         position;
    logic signed [31:0] popped_value;
    logic [8:0]         entry_count;
    logic signed [31:0] head_value;
    logic signed [31:0] tail_value;
  } out_beat_t;

  // write enables of the three node arrays
  typedef struct packed {
    logic val;
    logic nxt;
    logic prv;
  } node_we_t;

endpackage
`default_nettype wire

/* design/bdll_nodes.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bdll_nodes: node pool memory
// value, next link and prev link arrays, one shared registered read port
// ----------------------------------------------------------------------------
module bdll_nodes #(
  parameter int CAPACITY    = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                            clk_i,
  input  wire bdll_pkg::node_we_t              we_i,
  input  wire logic [$clog2(CAPACITY)-1:0]     val_waddr_i,
  input  wire logic [VALUE_WIDTH-1:0]          val_wdata_i,
  input  wire logic [$clog2(CAPACITY)-1:0]     next_waddr_i,
  input  wire logic [$clog2(CAPACITY):0]       next_wdata_i,
  input  wire logic [$clog2(CAPACITY)-1:0]     prev_waddr_i,
  input  wire logic [$clog2(CAPACITY):0]       prev_wdata_i,
  input  wire logic                            rd_en_i,
  input  wire logic [$clog2(CAPACITY)-1:0]     rd_addr_i,
  output logic      [VALUE_WIDTH-1:0]          rd_val_o,
  output logic      [$clog2(CAPACITY):0]       rd_next_o,
  output logic      [$clog2(CAPACITY):0]       rd_prev_o
);

  localparam int IW = $clog2(CAPACITY);

  logic [VALUE_WIDTH-1:0] val_mem  [CAPACITY];
  logic [IW:0]            next_mem [CAPACITY];
  logic [IW:0]            prev_mem [CAPACITY];

  always_ff @(posedge clk_i) begin
    if (we_i.val) val_mem[val_waddr_i] <= val_wdata_i;
    if (we_i.nxt) next_mem[next_waddr_i] <= next_wdata_i;
    if (we_i.prv) prev_mem[prev_waddr_i] <= prev_wdata_i;
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_val_o  <= val_mem[rd_addr_i];
      rd_next_o <= next_mem[rd_addr_i];
      rd_prev_o <= prev_mem[rd_addr_i];
    end
  end

endmodule
`default_nettype wire

/* design/bdll_fstack.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bdll_fstack: stack of released node indices
// pop data is registered and arrives in the cycle after the pop
// ----------------------------------------------------------------------------
module bdll_fstack #(
  parameter int CAPACITY = 256
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        clear_i,
  input  wire logic                        push_i,
  input  wire logic [$clog2(CAPACITY)-1:0] push_idx_i,
  input  wire logic                        pop_i,
  output logic      [$clog2(CAPACITY)-1:0] pop_idx_o,
  output logic                             empty_o
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [IW-1:0] stk_mem [CAPACITY];
  logic [CW-1:0] sp_q, sp_d, sp_dec;

  assign sp_dec  = sp_q - CW'(1);
  assign empty_o = (sp_q == '0);

  always_comb begin
    sp_d = sp_q;
    if (clear_i) sp_d = '0;
    else if (push_i) sp_d = sp_q + CW'(1);
    else if (pop_i) sp_d = sp_dec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
    end else begin
      sp_q <= sp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) stk_mem[sp_q[IW-1:0]] <= push_idx_i;
    if (pop_i) pop_idx_o <= stk_mem[sp_dec[IW-1:0]];
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> sp_q < CW'(CAPACITY)) else $error("free stack overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("free stack underflow");
  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && pop_i)) else $error("push and pop together");

endmodule
`default_nettype wire

/* design/bounded_doubly_linked_list.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_doubly_linked_list: ordered list of values in a fixed node pool
// push, insert after key, pop, remove, find and clear, one result per request
// ----------------------------------------------------------------------------
// A request beat is taken only while the sequencer is idle; its result beat
// sits in an output register, so the next request can be taken while that
// result still waits. Insert after, remove and find walk the list from the
// head one node per cycle through the registered read port of the node
// memory, and stop at a match, at the tail or once entry_count nodes are read.
// Nodes are handed out first from the stack of released nodes and then from a
// fresh counter, so no clearing pass is needed after reset or clear.
// ----------------------------------------------------------------------------
module bounded_doubly_linked_list #(
  parameter int CAPACITY    = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire bdll_pkg::in_beat_t  in_beat_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output bdll_pkg::out_beat_t      out_beat_o
);

  localparam int IW = $clog2(CAPACITY);
  localparam int LW = IW + 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [LW-1:0] NullIdx = LW'(CAPACITY);
  localparam logic [CW-1:0] CapCnt  = CW'(CAPACITY);

  bdll_pkg::state_e  state_q, state_d;
  bdll_pkg::req_e    req_q, req_d, in_req;
  bdll_pkg::status_e status_q, status_d;

  logic [VALUE_WIDTH-1:0] val_q, val_d, key_q, key_d;
  logic [VALUE_WIDTH-1:0] head_val_q, head_val_d, tail_val_q, tail_val_d;
  logic [VALUE_WIDTH-1:0] popped_q, popped_d;
  logic [IW-1:0]          cur_q, cur_d, node_q, node_d, at_q, at_d;
  logic [LW-1:0]          nbr_q, nbr_d, head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]          steps_q, steps_d, pos_q, pos_d, count_q, count_d;
  logic [CW-1:0]          fresh_q, fresh_d, steps_inc;
  logic                   fixh_q, fixh_d;
  logic                   out_valid_q;
  bdll_pkg::out_beat_t    out_q;

  // node memory port
  bdll_pkg::node_we_t     we;
  logic [IW-1:0]          val_waddr, next_waddr, prev_waddr, rd_addr;
  logic [VALUE_WIDTH-1:0] val_wdata, rd_val;
  logic [LW-1:0]          next_wdata, prev_wdata, rd_next, rd_prev;
  logic                   rd_en;

  // free stack port
  logic                   fs_clear, fs_push, fs_pop, fs_empty;
  logic [IW-1:0]          fs_idx;

  logic                   accept, out_free, alloc_go, is_empty, is_full;

  assign in_req    = bdll_pkg::req_e'(in_beat_i.req_type);
  assign in_stall_o = (state_q != bdll_pkg::S_IDLE);
  assign accept    = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign is_empty  = (count_q == '0);
  assign is_full   = (count_q == CapCnt);
  assign steps_inc = steps_q + CW'(1);

  bdll_nodes #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_nodes (
    .clk_i        (clk_i),
    .we_i         (we),
    .val_waddr_i  (val_waddr),
    .val_wdata_i  (val_wdata),
    .next_waddr_i (next_waddr),
    .next_wdata_i (next_wdata),
    .prev_waddr_i (prev_waddr),
    .prev_wdata_i (prev_wdata),
    .rd_en_i      (rd_en),
    .rd_addr_i    (rd_addr),
    .rd_val_o     (rd_val),
    .rd_next_o    (rd_next),
    .rd_prev_o    (rd_prev)
  );

  bdll_fstack #(
    .CAPACITY (CAPACITY)
  ) u_fstack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (fs_clear),
    .push_i     (fs_push),
    .push_idx_i (cur_q),
    .pop_i      (fs_pop),
    .pop_idx_o  (fs_idx),
    .empty_o    (fs_empty)
  );

  // sequencer
  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    status_d   = status_q;
    val_d      = val_q;
    key_d      = key_q;
    head_val_d = head_val_q;
    tail_val_d = tail_val_q;
    popped_d   = popped_q;
    cur_d      = cur_q;
    node_d     = node_q;
    at_d       = at_q;
    nbr_d      = nbr_q;
    head_d     = head_q;
    tail_d     = tail_q;
    steps_d    = steps_q;
    pos_d      = pos_q;
    count_d    = count_q;
    fresh_d    = fresh_q;
    fixh_d     = fixh_q;
    we         = '0;
    val_waddr  = node_q;
    val_wdata  = val_q;
    next_waddr = node_q;
    next_wdata = NullIdx;
    prev_waddr = node_q;
    prev_wdata = NullIdx;
    rd_en      = 1'b0;
    rd_addr    = cur_q;
    fs_clear   = 1'b0;
    fs_push    = 1'b0;
    fs_pop     = 1'b0;
    alloc_go   = 1'b0;

    case (state_q)
      bdll_pkg::S_IDLE: begin
        if (accept) begin
          req_d    = in_req;
          val_d    = VALUE_WIDTH'($unsigned(in_beat_i.new_value));
          key_d    = VALUE_WIDTH'($unsigned(in_beat_i.match_key));
          status_d = bdll_pkg::ST_OK;
          pos_d    = '0;
          popped_d = '0;
          steps_d  = '0;
          state_d  = bdll_pkg::S_RESP;
          case (in_req)
            bdll_pkg::REQ_PUSH_FRONT, bdll_pkg::REQ_PUSH_BACK: begin
              if (is_full) status_d = bdll_pkg::ST_FULL;
              else alloc_go = 1'b1;
            end
            bdll_pkg::REQ_INSERT, bdll_pkg::REQ_REMOVE, bdll_pkg::REQ_FIND: begin
              if (is_empty) begin
                status_d = bdll_pkg::ST_EMPTY;
              end else if (is_full && in_req == bdll_pkg::REQ_INSERT) begin
                status_d = bdll_pkg::ST_FULL;
              end else begin
                // start the walk at the head
                cur_d   = head_q[IW-1:0];
                rd_en   = 1'b1;
                rd_addr = head_q[IW-1:0];
                state_d = bdll_pkg::S_SRCH;
              end
            end
            bdll_pkg::REQ_POP_FRONT, bdll_pkg::REQ_POP_BACK: begin
              if (is_empty) begin
                status_d = bdll_pkg::ST_EMPTY;
              end else begin
                cur_d   = (in_req == bdll_pkg::REQ_POP_FRONT) ? head_q[IW-1:0]
                                                              : tail_q[IW-1:0];
                rd_en   = 1'b1;
                rd_addr = cur_d;
                state_d = bdll_pkg::S_UNLINK;
              end
            end
            default: begin
              // clear
              if (is_empty) status_d = bdll_pkg::ST_EMPTY;
              head_d     = NullIdx;
              tail_d     = NullIdx;
              head_val_d = '0;
              tail_val_d = '0;
              count_d    = '0;
              fresh_d    = '0;
              fs_clear   = 1'b1;
            end
          endcase
        end
      end

      bdll_pkg::S_ALLOC_W: begin
        node_d  = fs_idx;
        state_d = bdll_pkg::S_LINK1;
      end

      bdll_pkg::S_LINK1: begin
        we.val   = 1'b1;
        we.nxt   = 1'b1;
        we.prv   = 1'b1;
        count_d  = count_q + CW'(1);
        state_d  = bdll_pkg::S_LINK2;
        case (req_q)
          bdll_pkg::REQ_PUSH_FRONT: begin
            next_wdata = head_q;
            nbr_d      = head_q;
            head_d     = {1'b0, node_q};
            head_val_d = val_q;
            if (head_q == NullIdx) begin
              tail_d     = {1'b0, node_q};
              tail_val_d = val_q;
              state_d    = bdll_pkg::S_RESP;
            end
          end
          bdll_pkg::REQ_PUSH_BACK: begin
            prev_wdata = tail_q;
            nbr_d      = tail_q;
            tail_d     = {1'b0, node_q};
            tail_val_d = val_q;
            if (tail_q == NullIdx) begin
              head_d     = {1'b0, node_q};
              head_val_d = val_q;
              state_d    = bdll_pkg::S_RESP;
            end
          end
          default: begin
            // insert after the matched node
            prev_wdata = {1'b0, at_q};
            next_wdata = nbr_q;
          end
        endcase
      end

      bdll_pkg::S_LINK2: begin
        state_d = bdll_pkg::S_RESP;
        case (req_q)
          bdll_pkg::REQ_PUSH_FRONT: begin
            we.prv     = 1'b1;
            prev_waddr = nbr_q[IW-1:0];
            prev_wdata = {1'b0, node_q};
          end
          bdll_pkg::REQ_PUSH_BACK: begin
            we.nxt     = 1'b1;
            next_waddr = nbr_q[IW-1:0];
            next_wdata = {1'b0, node_q};
          end
          default: begin
            we.nxt     = 1'b1;
            next_waddr = at_q;
            next_wdata = {1'b0, node_q};
            if (nbr_q != NullIdx) begin
              we.prv     = 1'b1;
              prev_waddr = nbr_q[IW-1:0];
              prev_wdata = {1'b0, node_q};
            end else begin
              tail_d     = {1'b0, node_q};
              tail_val_d = val_q;
            end
          end
        endcase
      end

      bdll_pkg::S_SRCH: begin
        steps_d = steps_inc;
        if (rd_val == key_q) begin
          case (req_q)
            bdll_pkg::REQ_FIND: begin
              pos_d   = steps_inc;
              state_d = bdll_pkg::S_RESP;
            end
            bdll_pkg::REQ_REMOVE: begin
              // read data still holds the matched node
              state_d = bdll_pkg::S_UNLINK;
            end
            default: begin
              at_d     = cur_q;
              nbr_d    = rd_next;
              alloc_go = 1'b1;
            end
          endcase
        end else if (steps_inc == count_q || rd_next == NullIdx) begin
          status_d = bdll_pkg::ST_NOTFOUND;
          state_d  = bdll_pkg::S_RESP;
        end else begin
          cur_d   = rd_next[IW-1:0];
          rd_en   = 1'b1;
          rd_addr = rd_next[IW-1:0];
        end
      end

      bdll_pkg::S_UNLINK: begin
        popped_d = rd_val;
        count_d  = count_q - CW'(1);
        fs_push  = 1'b1;
        state_d  = bdll_pkg::S_RESP;
        if (rd_prev != NullIdx) begin
          we.nxt     = 1'b1;
          next_waddr = rd_prev[IW-1:0];
          next_wdata = rd_next;
        end else begin
          head_d = rd_next;
        end
        if (rd_next != NullIdx) begin
          we.prv     = 1'b1;
          prev_waddr = rd_next[IW-1:0];
          prev_wdata = rd_prev;
        end else begin
          tail_d = rd_prev;
        end
        if (rd_prev == NullIdx && rd_next == NullIdx) begin
          // last node gone
          head_val_d = '0;
          tail_val_d = '0;
        end else if (rd_prev == NullIdx) begin
          fixh_d  = 1'b1;
          rd_en   = 1'b1;
          rd_addr = rd_next[IW-1:0];
          state_d = bdll_pkg::S_FIXV;
        end else if (rd_next == NullIdx) begin
          fixh_d  = 1'b0;
          rd_en   = 1'b1;
          rd_addr = rd_prev[IW-1:0];
          state_d = bdll_pkg::S_FIXV;
        end
      end

      bdll_pkg::S_FIXV: begin
        if (fixh_q) head_val_d = rd_val;
        else tail_val_d = rd_val;
        state_d = bdll_pkg::S_RESP;
      end

      bdll_pkg::S_RESP: begin
        if (out_free) state_d = bdll_pkg::S_IDLE;
      end

      default: state_d = bdll_pkg::S_IDLE;
    endcase

    // node allocation: released nodes first, then fresh ones
    if (alloc_go) begin
      if (!fs_empty) begin
        fs_pop  = 1'b1;
        state_d = bdll_pkg::S_ALLOC_W;
      end else begin
        node_d  = fresh_q[IW-1:0];
        fresh_d = fresh_q + CW'(1);
        state_d = bdll_pkg::S_LINK1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= bdll_pkg::S_IDLE;
      head_q     <= NullIdx;
      tail_q     <= NullIdx;
      head_val_q <= '0;
      tail_val_q <= '0;
      count_q    <= '0;
      fresh_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      head_val_q <= head_val_d;
      tail_val_q <= tail_val_d;
      count_q    <= count_d;
      fresh_q    <= fresh_d;
      if (state_q == bdll_pkg::S_RESP && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // per-request working registers
  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    status_q <= status_d;
    val_q    <= val_d;
    key_q    <= key_d;
    popped_q <= popped_d;
    cur_q    <= cur_d;
    node_q   <= node_d;
    at_q     <= at_d;
    nbr_q    <= nbr_d;
    steps_q  <= steps_d;
    pos_q    <= pos_d;
    fixh_q   <= fixh_d;
  end

  // result beat register
  always_ff @(posedge clk_i) begin
    if (state_q == bdll_pkg::S_RESP && out_free) begin
      out_q.status       <= status_q;
      out_q.position     <= 9'(pos_q);
      out_q.popped_value <= 32'(popped_q);
      out_q.entry_count  <= 9'(count_q);
      out_q.head_value   <= 32'(head_val_q);
      out_q.tail_value   <= 32'(tail_val_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCnt) else $error("entry count above capacity");
  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bdll_pkg::S_IDLE |-> ((count_q == '0) == (head_q == NullIdx)))
    else $error("head link disagrees with count");
  a_empty_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bdll_pkg::S_IDLE |-> ((count_q == '0) == (tail_q == NullIdx)))
    else $error("tail link disagrees with count");
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bdll_pkg::S_IDLE && count_q == CW'(1)) |-> head_q == tail_q)
    else $error("single entry with distinct head and tail");

endmodule
`default_nettype wire
